// ----- hdl/wsst_pkg.sv -----
// Shared types and constants for the working-set size tracker.
package wsst_pkg;

  localparam int unsigned PAGE_W       = 8;
  localparam int unsigned WIN_W        = 5;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned SUM_W        = 21;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);
  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX      = {SUM_W{1'b1}};

  // one history slot as handed from cell to cell
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              vld;   // reference taken since the last restart
    logic              dup;   // a newer slot holds the same page
  } entry_t;

endpackage

// ----- hdl/wsst_cell.sv -----
// One history slot of the tracker chain: page, valid and duplicate flags.
module wsst_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift,
  input  logic                          restart,
  input  logic [wsst_pkg::PAGE_W-1:0]   page,
  input  logic [wsst_pkg::WIN_W-1:0]    window,
  input  wsst_pkg::entry_t              prev,
  output wsst_pkg::entry_t              nxt_o,
  output logic                          hit
);
  import wsst_pkg::*;

  logic [PAGE_W-1:0] page_r;
  logic              vld_r;
  logic              dup_r;
  logic              same;
  logic              in_win;

  assign same   = (page_r == page);
  assign in_win = (32'(window) > IDX);

  // counts toward the size when it is the newest copy of its page in the window
  assign hit = !restart && vld_r && !dup_r && !same && in_win;

  assign nxt_o.page = page_r;
  assign nxt_o.vld  = vld_r & ~restart;
  assign nxt_o.dup  = dup_r | same;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift) begin
      vld_r <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      page_r <= prev.page;
      dup_r  <= prev.dup;
    end
  end

endmodule

// ----- hdl/wsst_stats.sv -----
// Running statistics and output register of the tracker.
module wsst_stats #(
  parameter int unsigned SIZE_W    = 5,
  parameter int unsigned SIZE_INIT = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [SIZE_W-1:0]           size,
  input  logic                        restart,
  input  logic                        out_stall,
  output logic                        free,
  output logic                        out_valid,
  output logic [wsst_pkg::CNT_W-1:0]  out_time_index,
  output logic [SIZE_W-1:0]           out_ws_size,
  output logic [SIZE_W-1:0]           out_min_size,
  output logic [SIZE_W-1:0]           out_max_size,
  output logic [wsst_pkg::SUM_W-1:0]  out_size_sum
);
  import wsst_pkg::*;

  logic              valid_r;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt,  cnt_base;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] min_r,  min_nxt,  min_base;
  logic [SIZE_W-1:0] max_r,  max_nxt,  max_base;
  logic [SUM_W-1:0]  sum_r,  sum_nxt,  sum_base;
  logic [SUM_W-1:0]  size_x;

  assign free   = !valid_r || !out_stall;
  assign size_x = SUM_W'(size);

  always_comb begin
    cnt_base = restart ? '0 : cnt_r;
    min_base = restart ? SIZE_W'(SIZE_INIT) : min_r;
    max_base = restart ? '0 : max_r;
    sum_base = restart ? '0 : sum_r;
    cnt_nxt  = (cnt_base == CNT_MAX) ? CNT_MAX : cnt_base + CNT_W'(1);
    min_nxt  = (size < min_base) ? size : min_base;
    max_nxt  = (size > max_base) ? size : max_base;
    sum_nxt  = (sum_base > SUM_MAX - size_x) ? SUM_MAX : sum_base + size_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
      min_r   <= SIZE_W'(SIZE_INIT);
      max_r   <= '0;
      sum_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      cnt_r   <= cnt_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      size_r <= size;
    end
  end

  assign out_valid      = valid_r;
  assign out_time_index = cnt_r;
  assign out_ws_size    = size_r;
  assign out_min_size   = min_r;
  assign out_max_size   = max_r;
  assign out_size_sum   = sum_r;

endmodule

// ----- hdl/working_set_size_tracker.sv -----
// Top level of the working-set size tracker: cell chain, size stage, stats.
//
// Use: one page reference per input beat (in_page, in_restart). Each beat
// yields exactly one result beat carrying the working-set size (distinct
// pages among this reference and up to window_size earlier ones since the
// last restart), running min/max/sum of sizes and the saturating reference
// count. in_restart=1 starts a new string before the page is taken.
// Config: cfg_window_size is written with cfg_valid; cfg_ready is always
// high. Values above WINDOW_MAX act as WINDOW_MAX. Write only while idle.
// Throughput: one beat per cycle while out_stall does not back up the
// stages; the history is a shift chain of WINDOW_MAX cells, each comparing
// its page with the incoming one, so no per-page memory is walked.
// Stages: cell chain -> hit vector reg -> size reg (popcount) -> stats/output
// reg. Each stage holds while the next is full, so bubbles squeeze out and a
// new beat is taken even while a result waits on out_stall.
// Reset: history marked empty, statistics cleared, window_size = 5, pipeline
// emptied. out_stall backs up stage by stage; in_stall rises only when all
// three stages hold beats. A stalled result stays stable on the ports.
module working_set_size_tracker #(
  parameter  int unsigned WINDOW_MAX = 16,
  localparam int unsigned SIZE_W     = $clog2(WINDOW_MAX + 2)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wsst_pkg::WIN_W-1:0]  cfg_window_size,
  // reference beats
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wsst_pkg::PAGE_W-1:0] in_page,
  input  logic                        in_restart,
  // result beats
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wsst_pkg::CNT_W-1:0]  out_time_index,
  output logic [SIZE_W-1:0]           out_ws_size,
  output logic [SIZE_W-1:0]           out_min_size,
  output logic [SIZE_W-1:0]           out_max_size,
  output logic [wsst_pkg::SUM_W-1:0]  out_size_sum
);
  import wsst_pkg::*;

  logic [WIN_W-1:0]      window_r;
  logic                  accept;
  entry_t                head;
  entry_t                chain [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] hits;

  // stage 1: hit vector
  logic                  s1_v_r;
  logic [WINDOW_MAX-1:0] s1_hits_r;
  logic                  s1_rst_r;
  logic                  s1_free, s1_move;
  // stage 2: size
  logic                  s2_v_r;
  logic [SIZE_W-1:0]     s2_size_r, s2_size_nxt;
  logic                  s2_rst_r;
  logic                  s2_free, s2_move;
  logic                  s3_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_valid) begin
      window_r <= cfg_window_size;
    end
  end

  // backpressure, collapsing bubbles
  assign s2_move  = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_move  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && !in_stall;

  // newest reference enters cell 0; it never counts as its own duplicate
  assign head.page = in_page;
  assign head.vld  = 1'b1;
  assign head.dup  = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    wsst_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (accept),
      .restart (in_restart),
      .page    (in_page),
      .window  (window_r),
      .prev    ((i == 0) ? head : chain[(i == 0) ? 0 : i - 1]),
      .nxt_o   (chain[i]),
      .hit     (hits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hits_r <= hits;
      s1_rst_r  <= in_restart;
    end
  end

  // size = current page plus every newest-copy earlier page in the window
  always_comb begin
    s2_size_nxt = SIZE_W'(1);
    for (int k = 0; k < WINDOW_MAX; k++) begin
      s2_size_nxt = s2_size_nxt + SIZE_W'(s1_hits_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_move) begin
      s2_v_r <= 1'b1;
    end else if (s2_move) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_size_r <= s2_size_nxt;
      s2_rst_r  <= s1_rst_r;
    end
  end

  wsst_stats #(
    .SIZE_W    (SIZE_W),
    .SIZE_INIT (WINDOW_MAX + 1)
  ) u_stats (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s2_move),
    .size           (s2_size_r),
    .restart        (s2_rst_r),
    .out_stall      (out_stall),
    .free           (s3_free),
    .out_valid      (out_valid),
    .out_time_index (out_time_index),
    .out_ws_size    (out_ws_size),
    .out_min_size   (out_min_size),
    .out_max_size   (out_max_size),
    .out_size_sum   (out_size_sum)
  );

endmodule

// ----- hdl/wsst_checker.sv -----
// Port-level checks for the working-set size tracker, bound to the top level.
module wsst_checker #(
  parameter int unsigned SIZE_W = 5
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [wsst_pkg::CNT_W-1:0] out_time_index,
  input logic [SIZE_W-1:0]          out_ws_size,
  input logic [SIZE_W-1:0]          out_min_size,
  input logic [SIZE_W-1:0]          out_max_size,
  input logic [wsst_pkg::SUM_W-1:0] out_size_sum
);
  import wsst_pkg::*;

  // held result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ws_size)
      && $stable(out_size_sum) && $stable(out_time_index))
    else $error("stalled result changed");

  // reset empties the output stage
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // size lies between running min and max
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ws_size != '0 && out_min_size <= out_ws_size
      && out_ws_size <= out_max_size)
    else $error("size outside min/max");

  // first reference of a string seeds all statistics
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_time_index == CNT_W'(1) |-> out_min_size == out_ws_size
      && out_max_size == out_ws_size && out_size_sum == SUM_W'(out_ws_size))
    else $error("first beat statistics wrong");

endmodule

bind working_set_size_tracker wsst_checker #(.SIZE_W(SIZE_W)) u_wsst_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the working-set size tracker: directed, random and full-rate runs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsst_pkg::*;

  localparam int unsigned WIN_MAX    = 16;
  localparam int unsigned SZ_W       = $clog2(WIN_MAX + 2);
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam int unsigned FLOOD_REFS = 200;  // length of the full-rate string

  // One result beat, field for field as it leaves the block.
  typedef struct packed {
    logic [CNT_W-1:0] time_index;
    logic [SZ_W-1:0]  ws_size;
    logic [SZ_W-1:0]  min_size;
    logic [SZ_W-1:0]  max_size;
    logic [SUM_W-1:0] size_sum;
  } ws_result_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [WIN_W-1:0]  cfg_window_size = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PAGE_W-1:0] in_page = '0;
  logic              in_restart = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CNT_W-1:0]  out_time_index;
  logic [SZ_W-1:0]   out_ws_size;
  logic [SZ_W-1:0]   out_min_size;
  logic [SZ_W-1:0]   out_max_size;
  logic [SUM_W-1:0]  out_size_sum;

  working_set_size_tracker #(.WINDOW_MAX(WIN_MAX)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_size(cfg_window_size),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_page        (in_page),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_time_index (out_time_index),
    .out_ws_size    (out_ws_size),
    .out_min_size   (out_min_size),
    .out_max_size   (out_max_size),
    .out_size_sum   (out_size_sum)
  );

  // Predictor state: our own copy of the page history, stats and window register.
  logic [PAGE_W-1:0] hist [WIN_MAX];  // newest first
  int unsigned       refs;
  int unsigned       lo_size;
  int unsigned       hi_size;
  int unsigned       size_total;
  int unsigned       win_reg;

  ws_result_t  sizes_due [$];  // predicted beats not yet seen on the output
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          flood = 1'b0;   // no gaps, no stalls: used for the long full-rate string

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void clear_string();
    foreach (hist[i]) hist[i] = '0;
    refs       = 0;
    lo_size    = WIN_MAX + 1;
    hi_size    = 0;
    size_total = 0;
  endfunction

  // Working-set size of the new reference plus the running stats; advances the history.
  function automatic ws_result_t track_ref(input logic [PAGE_W-1:0] page, input logic restart);
    int unsigned span;
    int unsigned size;
    bit          fresh;
    ws_result_t  r;
    if (restart)
      clear_string();
    // oversized window clamps to the history depth, then to what exists since restart
    span = (win_reg > WIN_MAX) ? WIN_MAX : win_reg;
    if (span > refs)
      span = refs;
    size = 1;
    for (int i = 0; i < span; i++) begin
      fresh = (hist[i] != page);
      for (int j = 0; j < i; j++)
        if (hist[j] == hist[i])
          fresh = 1'b0;
      if (fresh)
        size++;
    end
    for (int i = WIN_MAX - 1; i > 0; i--)
      hist[i] = hist[i-1];
    hist[0] = page;
    if (refs < CNT_MAX)
      refs++;
    if (size < lo_size)
      lo_size = size;
    if (size > hi_size)
      hi_size = size;
    if (size_total > SUM_MAX - size)
      size_total = SUM_MAX;
    else
      size_total += size;
    r.time_index = refs[CNT_W-1:0];
    r.ws_size    = size[SZ_W-1:0];
    r.min_size   = lo_size[SZ_W-1:0];
    r.max_size   = hi_size[SZ_W-1:0];
    r.size_sum   = size_total[SUM_W-1:0];
    return r;
  endfunction

  // Receiver stall pattern: a fresh pattern each time stall_step wraps, in one of four moods:
  // never stall, random bits, sparse bits, or a solid stall.
  logic [31:0] stall_bits = '0;
  int unsigned stall_mood = 0;
  logic [4:0]  stall_step = '0;

  always @(posedge clk) begin
    if (stall_step == 0) begin
      stall_bits = $urandom;
      stall_mood = $urandom_range(0, 3);
    end
    stall_step <= stall_step + 1'b1;
    if (flood || stall_mood == 0)
      out_stall <= 1'b0;
    else if (stall_mood == 1)
      out_stall <= stall_bits[stall_step];
    else if (stall_mood == 2)
      out_stall <= stall_bits[stall_step] & stall_bits[~stall_step];
    else
      out_stall <= 1'b1;
  end

  task automatic note_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Result checker: every accepted beat against the oldest prediction.
  always @(posedge clk) begin
    ws_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sizes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected", $realtime);
      end else begin
        want = sizes_due.pop_front();
        note_field("time_index", want.time_index, out_time_index);
        note_field("ws_size", want.ws_size, out_ws_size);
        note_field("min_size", want.min_size, out_min_size);
        note_field("max_size", want.max_size, out_max_size);
        note_field("size_sum", want.size_sum, out_size_sum);
      end
    end
  end

  // Sends one reference beat. Entered just after a rising edge; returns just after
  // the edge that accepted it. Bursts of random length with random gaps between.
  task automatic send_ref(input logic [PAGE_W-1:0] page, input logic restart);
    int unsigned gap;
    if (!flood && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0)
      burst_left--;
    in_valid   <= 1'b1;
    in_page    <= page;
    in_restart <= restart;
    sizes_due = {sizes_due, track_ref(page, restart)};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops input and waits for every predicted beat, plus the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (sizes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Window register write, only with the block idle.
  task automatic set_window(input int unsigned w);
    drain();
    cfg_valid       <= 1'b1;
    cfg_window_size <= w[WIN_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_reg = w;
  endtask

  // Reset window of 5: history grows from empty, page extremes repeat.
  task automatic test_short_history();
    send_ref(8'd0, 1'b0);
    send_ref(8'd255, 1'b0);
    send_ref(8'd0, 1'b0);
    send_ref(8'd255, 1'b0);
    for (int p = 1; p <= 6; p++)
      send_ref(p[PAGE_W-1:0], 1'b0);
  endtask

  // Zero window, oversized windows, and a window change in the middle of a string.
  task automatic test_window_extremes();
    set_window(0);
    send_ref(8'd7, 1'b0);
    send_ref(8'd9, 1'b0);
    set_window(31);
    send_ref(8'd255, 1'b1);
    for (int p = 40; p < 45; p++)
      send_ref(p[PAGE_W-1:0], 1'b0);
    set_window(16);  // no restart: the new window reads the kept history at once
    send_ref(8'd40, 1'b0);
    send_ref(8'd128, 1'b0);
    send_ref(8'd1, 1'b0);
    set_window(17);
    send_ref(8'd2, 1'b0);
    send_ref(8'd3, 1'b0);
  endtask

  // Random strings: mostly pages drawn from a small pool so the window sees repeats,
  // some full-range pages and stray restarts as noise. Window changes between phases.
  task automatic test_random_strings();
    int unsigned left;
    int unsigned len;
    int unsigned pool;
    int unsigned base;
    logic [PAGE_W-1:0] page;
    logic              restart;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0)
        set_window(16);
      else if (phase == 1)
        set_window(0);
      else
        set_window($urandom_range(0, 31));
      left = 220;
      while (left > 0) begin
        len  = $urandom_range(1, 120);
        pool = $urandom_range(0, 24);
        base = $urandom_range(0, 255);
        restart = ($urandom_range(0, 1) == 0);
        for (int k = 0; k < len && left > 0; k++) begin
          if ($urandom_range(0, 15) == 0)
            page = PAGE_W'($urandom_range(0, 255));
          else
            page = PAGE_W'(base + $urandom_range(0, pool));
          if (k > 0)
            restart = ($urandom_range(0, 99) == 0);
          send_ref(page, restart);
          left--;
        end
      end
    end
  endtask

  // One long string at full rate with up to 17 distinct pages in each window, then
  // random pages and a restart that clears the statistics.
  task automatic test_full_rate();
    set_window(16);
    flood = 1'b1;
    send_ref(8'd0, 1'b1);
    for (int unsigned n = 1; n < FLOOD_REFS; n++)
      send_ref(n[PAGE_W-1:0], 1'b0);
    flood = 1'b0;
    for (int n = 0; n < 20; n++)
      send_ref(PAGE_W'($urandom_range(0, 255)), 1'b0);
    send_ref(8'd77, 1'b1);
    send_ref(8'd77, 1'b0);
    send_ref(8'd78, 1'b0);
  endtask

  initial begin
    win_reg = WINDOW_RESET;
    clear_string();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_history();
    test_window_extremes();
    test_random_strings();
    test_full_rate();

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
